// ===== hw/rtl/iir4_pkg.sv =====
package iir4_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int HALF_W     = 32;
  localparam int NUM_REGS   = 5;

  // delay line: 40-bit signed, 8 fraction bits
  localparam int ORDER      = 4;
  localparam int STATE_W    = 40;
  localparam int STATE_FRAC = 8;
  // the state word is split here for the two partial products
  localparam int WL_W       = 20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A2_A3   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A4_B0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B3_B4   = 3'd4;

  // coefficient slots, in register order
  typedef enum logic [3:0] {
    C_GAIN = 4'd0,
    C_A1   = 4'd1,
    C_A2   = 4'd2,
    C_A3   = 4'd3,
    C_A4   = 4'd4,
    C_B0   = 4'd5,
    C_B1   = 4'd6,
    C_B2   = 4'd7,
    C_B3   = 4'd8,
    C_B4   = 4'd9
  } coef_sel_t;

  localparam int NUM_COEF = 10;

  // multiplier state operand
  typedef enum logic [2:0] {
    OP_W1  = 3'd0,
    OP_W2  = 3'd1,
    OP_W3  = 3'd2,
    OP_W4  = 3'd3,
    OP_TMP = 3'd4
  } opnd_t;

  // controller -> datapath command, one per cycle
  typedef struct packed {
    logic      ld_x;     // load sample into feedback accumulator
    logic      mac;      // issue a product into the multiplier
    coef_sel_t coef_sel;
    opnd_t     opnd;
    logic      acc_b;    // product goes to feedforward accumulator
    logic      sub;      // subtract product
    logic      load;     // overwrite accumulator with product
    logic      rnd_d;    // round feedback accumulator into temp
    logic      rnd_w;    // round feedback accumulator, shift delay line
    logic      ld_y;     // round feedforward accumulator into output register
  } cmd_t;

endpackage

// ===== hw/rtl/iir4_ctrl.sv =====
module iir4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output iir4_pkg::cmd_t cmd
);
  import iir4_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // schedule positions
  localparam logic [3:0] STEP_A1    = 4'd0;
  localparam logic [3:0] STEP_A2    = 4'd1;
  localparam logic [3:0] STEP_A3    = 4'd2;
  localparam logic [3:0] STEP_A4    = 4'd3;
  localparam logic [3:0] STEP_B1    = 4'd4;
  localparam logic [3:0] STEP_B2    = 4'd5;
  localparam logic [3:0] STEP_B3_D  = 4'd6;
  localparam logic [3:0] STEP_GAIN  = 4'd7;
  localparam logic [3:0] STEP_B4    = 4'd8;
  localparam logic [3:0] STEP_W0    = 4'd10;
  localparam logic [3:0] STEP_B0    = 4'd11;
  localparam logic [3:0] STEP_LAST  = 4'd14;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  function automatic cmd_t mac_cmd(coef_sel_t c, opnd_t o, logic to_b, logic s, logic l);
    cmd_t m;
    m          = '0;
    m.mac      = 1'b1;
    m.coef_sel = c;
    m.opnd     = o;
    m.acc_b    = to_b;
    m.sub      = s;
    m.load     = l;
    return m;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_x  = 1'b1;
          state_nxt = ST_RUN;
          step_nxt  = STEP_A1;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          STEP_A1:   cmd = mac_cmd(C_A1, OP_W1, 1'b0, 1'b1, 1'b0);
          STEP_A2:   cmd = mac_cmd(C_A2, OP_W2, 1'b0, 1'b1, 1'b0);
          STEP_A3:   cmd = mac_cmd(C_A3, OP_W3, 1'b0, 1'b1, 1'b0);
          STEP_A4:   cmd = mac_cmd(C_A4, OP_W4, 1'b0, 1'b1, 1'b0);
          STEP_B1:   cmd = mac_cmd(C_B1, OP_W1, 1'b1, 1'b0, 1'b1);
          STEP_B2:   cmd = mac_cmd(C_B2, OP_W2, 1'b1, 1'b0, 1'b0);
          STEP_B3_D: begin
            cmd       = mac_cmd(C_B3, OP_W3, 1'b1, 1'b0, 1'b0);
            cmd.rnd_d = 1'b1;
          end
          STEP_GAIN: cmd = mac_cmd(C_GAIN, OP_TMP, 1'b0, 1'b0, 1'b1);
          STEP_B4:   cmd = mac_cmd(C_B4, OP_W4, 1'b1, 1'b0, 1'b0);
          STEP_W0:   cmd.rnd_w = 1'b1;
          // w0 now sits in the first delay slot
          STEP_B0:   cmd = mac_cmd(C_B0, OP_W1, 1'b1, 1'b0, 1'b0);
          STEP_LAST: begin
            if (!out_valid_r || out_ready) begin
              cmd.ld_y      = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_HOLD;
            end
          end
          default: ;
        endcase
      end
      ST_HOLD: begin
        if (out_ready) begin
          cmd.ld_y      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/iir4_dp.sv =====
module iir4_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iir4_pkg::cmd_t                      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  input  logic                                cfg_we,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iir4_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import iir4_pkg::*;

  localparam int COEF_FRAC = COEF_WIDTH - 4;
  localparam int FB_SH     = COEF_FRAC;               // feedback rounding shift
  localparam int Y_SH      = COEF_FRAC + STATE_FRAC;  // output rounding shift
  localparam int PLO_W     = COEF_WIDTH + WL_W + 1;
  localparam int PHI_W     = COEF_WIDTH + STATE_W - WL_W;
  localparam int PROD_W    = COEF_WIDTH + STATE_W;
  localparam int ACC_W     = PROD_W + 4;

  typedef struct packed {
    logic acc_b;
    logic sub;
    logic load;
  } tag_t;

  logic signed [COEF_WIDTH-1:0] coef_r [NUM_COEF];
  logic signed [STATE_W-1:0]    dl_r [ORDER];
  logic signed [STATE_W-1:0]    tmp_r;

  logic signed [COEF_WIDTH-1:0] coef;
  logic signed [STATE_W-1:0]    opnd;
  logic signed [WL_W:0]         w_lo;
  logic signed [STATE_W-WL_W-1:0] w_hi;

  logic signed [PLO_W-1:0]  p_lo_r, p_lo_nxt;
  logic signed [PHI_W-1:0]  p_hi_r, p_hi_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     v1_r, v2_r;
  tag_t                     tag1_r, tag2_r;

  logic signed [ACC_W-1:0]  acc_a_r, acc_b_r, acc_sel, acc_base, acc_nxt;
  logic signed [ACC_W-1:0]  rnd_a, sh_a, rnd_b, sh_b;
  logic [ACC_W-STATE_W:0]   fb_hi;
  logic [ACC_W-SAMPLE_WIDTH:0] y_hi;
  logic signed [STATE_W-1:0]      fb_val;
  logic signed [SAMPLE_WIDTH-1:0] y_val, y_r;

  // coefficient registers, two per configuration word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_A1: begin
          coef_r[C_GAIN] <= cfg_wdata[HALF_W +: COEF_WIDTH];
          coef_r[C_A1]   <= cfg_wdata[0 +: COEF_WIDTH];
        end
        REG_A2_A3: begin
          coef_r[C_A2] <= cfg_wdata[HALF_W +: COEF_WIDTH];
          coef_r[C_A3] <= cfg_wdata[0 +: COEF_WIDTH];
        end
        REG_A4_B0: begin
          coef_r[C_A4] <= cfg_wdata[HALF_W +: COEF_WIDTH];
          coef_r[C_B0] <= cfg_wdata[0 +: COEF_WIDTH];
        end
        REG_B1_B2: begin
          coef_r[C_B1] <= cfg_wdata[HALF_W +: COEF_WIDTH];
          coef_r[C_B2] <= cfg_wdata[0 +: COEF_WIDTH];
        end
        REG_B3_B4: begin
          coef_r[C_B3] <= cfg_wdata[HALF_W +: COEF_WIDTH];
          coef_r[C_B4] <= cfg_wdata[0 +: COEF_WIDTH];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.coef_sel)
      C_GAIN:  coef = coef_r[C_GAIN];
      C_A1:    coef = coef_r[C_A1];
      C_A2:    coef = coef_r[C_A2];
      C_A3:    coef = coef_r[C_A3];
      C_A4:    coef = coef_r[C_A4];
      C_B0:    coef = coef_r[C_B0];
      C_B1:    coef = coef_r[C_B1];
      C_B2:    coef = coef_r[C_B2];
      C_B3:    coef = coef_r[C_B3];
      C_B4:    coef = coef_r[C_B4];
      default: coef = '0;
    endcase
    case (cmd.opnd)
      OP_W1:   opnd = dl_r[0];
      OP_W2:   opnd = dl_r[1];
      OP_W3:   opnd = dl_r[2];
      OP_W4:   opnd = dl_r[3];
      OP_TMP:  opnd = tmp_r;
      default: opnd = '0;
    endcase
  end

  // stage 1: two partial products, low state bits unsigned, high bits signed
  assign w_lo     = {1'b0, opnd[WL_W-1:0]};
  assign w_hi     = opnd[STATE_W-1:WL_W];
  assign p_lo_nxt = coef * w_lo;
  assign p_hi_nxt = coef * w_hi;

  // stage 2: recombine
  assign prod_nxt = PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) <<< WL_W);

  // stage 3: accumulate
  assign acc_sel  = tag2_r.acc_b ? acc_b_r : acc_a_r;
  assign acc_base = tag2_r.load ? '0 : acc_sel;
  assign acc_nxt  = tag2_r.sub ? (acc_base - ACC_W'(prod_r)) : (acc_base + ACC_W'(prod_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_lo_r <= p_lo_nxt;
    p_hi_r <= p_hi_nxt;
    tag1_r <= '{acc_b: cmd.acc_b, sub: cmd.sub, load: cmd.load};
    prod_r <= prod_nxt;
    tag2_r <= tag1_r;
    if (cmd.ld_x) begin
      acc_a_r <= ACC_W'(in_sample_in) <<< Y_SH;
    end else if (v2_r && !tag2_r.acc_b) begin
      acc_a_r <= acc_nxt;
    end
    if (v2_r && tag2_r.acc_b) begin
      acc_b_r <= acc_nxt;
    end
  end

  // round to nearest (ties up), then saturate
  assign rnd_a  = acc_a_r + (ACC_W'(1) <<< (FB_SH - 1));
  assign sh_a   = rnd_a >>> FB_SH;
  assign fb_hi  = sh_a[ACC_W-1:STATE_W-1];
  assign fb_val = ((&fb_hi) || !(|fb_hi)) ? sh_a[STATE_W-1:0] :
                  (sh_a[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} :
                                   {1'b0, {(STATE_W-1){1'b1}}});

  assign rnd_b  = acc_b_r + (ACC_W'(1) <<< (Y_SH - 1));
  assign sh_b   = rnd_b >>> Y_SH;
  assign y_hi   = sh_b[ACC_W-1:SAMPLE_WIDTH-1];
  assign y_val  = ((&y_hi) || !(|y_hi)) ? sh_b[SAMPLE_WIDTH-1:0] :
                  (sh_b[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} :
                                   {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER; i++) dl_r[i] <= '0;
    end else if (cmd.rnd_w) begin
      dl_r[0] <= fb_val;
      for (int i = 1; i < ORDER; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd_d) tmp_r <= fb_val;
    if (cmd.ld_y)  y_r   <= y_val;
  end

  assign sample_out = y_r;

endmodule

// ===== hw/rtl/iir_fourth_order_direct_form_two_unit.sv =====
// Fourth-order direct form II IIR filter. Each input item (a signed
// SAMPLE_WIDTH-bit sample) gives exactly one output item. The feedback sum
// x - a1*w1 - .. - a4*w4 is formed exactly, rounded to nearest (ties up) to a
// 40-bit state with 8 fraction bits and saturated; it is then scaled by the
// gain, rounded and saturated again to give the new state w0. The output
// b0*w0 + b1*w1 + .. + b4*w4 is rounded to an integer and saturated to
// SAMPLE_WIDTH bits; the four-entry delay line shifts as w0 is written.
// Coefficients are signed Q4.(COEF_WIDTH-4), two per 64-bit configuration
// word (first one in bits 63:32), taken from the low COEF_WIDTH bits of each
// half; register order is gain/a1, a2/a3, a4/b0, b1/b2, b3/b4, and a write
// to any other index is dropped. Write configuration only while no item is
// in flight. The block takes a new item only once it has finished the
// previous one: every item runs on one shared 3-stage multiply-accumulate
// pipeline and through the serial dependency d -> w0 -> y. The result
// sits in an output register, so the next item is accepted while it waits;
// the block only stalls when a second result is ready before the first has
// been taken.
module iir_fourth_order_direct_form_two_unit #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  // result item channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  out_sample_out,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iir4_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import iir4_pkg::*;

  cmd_t cmd;

  // sequencer: owns the handshakes and the per-cycle MAC schedule
  iir4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // coefficients, delay line, multiplier pipeline, accumulators, rounding
  iir4_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_sample_in (in_sample_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .sample_out   (out_sample_out)
  );

endmodule

// ===== hw/rtl/iir4_chk.sv =====
module iir4_chk #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result changed or dropped while stalled");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // an accepted item keeps the block busy through its schedule
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##15 !in_ready)
    else $error("item accepted before previous one finished");

  // a new result only appears at the end of an item's work
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in flight");

endmodule

bind iir_fourth_order_direct_form_two_unit iir4_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iir4_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);

// ===== bench/tb_iir_fourth_order_direct_form_two_unit.sv =====
`timescale 1ns / 100ps

module tb_iir_fourth_order_direct_form_two_unit;
  import iir4_pkg::*;

  localparam int SW          = 24;
  localparam int COEF_FRAC   = HALF_W - 4;   // Q4.28 coefficients
  localparam int LONG_HOLD   = 500;          // receiver hold-off, cycles
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;           // tail wait before the verdict

  // coefficient value ranges used when building random coefficient sets
  typedef enum int {SPAN_QUARTER, SPAN_UNIT, SPAN_FULL, SPAN_CORNER} span_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SW-1:0]    in_sample_in;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SW-1:0]    out_sample_out;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // filter model: coefficient words as written, and the delay line w1..w4
  logic [CFG_DATA_W-1:0]   coef_words [NUM_REGS];
  logic [CFG_DATA_W-1:0]   coef_plan  [NUM_REGS];
  logic signed [STATE_W-1:0] w_line   [ORDER];

  logic signed [SW-1:0]    pending_samples  [$];
  logic signed [SW-1:0]    expected_samples [$];

  bit quiet_phase;   // no idling on either side
  int send_gap;
  int recv_gap;
  int hold_left;
  int hold_count;
  logic hold_off;
  int results_seen;
  int errors;
  int cycle_count;

  iir_fourth_order_direct_form_two_unit #(
    .SAMPLE_WIDTH(SW),
    .COEF_WIDTH  (HALF_W)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Filter prediction. All sums are exact in 128-bit signed arithmetic;
  // the widest one (x << 36 plus four 72-bit products) needs about 75 bits.
  // ---------------------------------------------------------------------

  // coefficient k: even k is the upper half of word k/2, odd k the lower
  function automatic logic signed [127:0] coef_of(input int k);
    logic [CFG_DATA_W-1:0]   word;
    logic signed [HALF_W-1:0] half;
    word = coef_words[k / 2];
    half = (k % 2 == 1) ? word[HALF_W-1:0] : word[CFG_DATA_W-1:HALF_W];
    return 128'(half);
  endfunction

  // round right by sh, nearest with ties toward +inf, then clamp to w bits
  function automatic logic signed [127:0] round_sat(input logic signed [127:0] acc,
                                                    input int sh, input int w);
    logic signed [127:0] r;
    logic signed [127:0] lim;
    r   = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
    lim = 128'sd1 <<< (w - 1);
    if (r > lim - 128'sd1)
      r = lim - 128'sd1;
    else if (r < -lim)
      r = -lim;
    return r;
  endfunction

  // one sample through feedback, gain and feedforward; shifts the delay line
  function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
    logic signed [127:0] acc;
    logic signed [127:0] d;
    logic signed [127:0] w0;
    logic signed [127:0] y;
    logic signed [127:0] wv;
    acc = 128'(x);
    acc = acc <<< (STATE_FRAC + COEF_FRAC);
    for (int i = 0; i < ORDER; i++) begin
      wv  = 128'(w_line[i]);
      acc = acc - coef_of(C_A1 + i) * wv;
    end
    d  = round_sat(acc, COEF_FRAC, STATE_W);
    w0 = round_sat(coef_of(C_GAIN) * d, COEF_FRAC, STATE_W);
    acc = coef_of(C_B0) * w0;
    for (int i = 0; i < ORDER; i++) begin
      wv  = 128'(w_line[i]);
      acc = acc + coef_of(C_B1 + i) * wv;
    end
    y = round_sat(acc, STATE_FRAC + COEF_FRAC, SW);
    for (int i = ORDER - 1; i > 0; i--)
      w_line[i] = w_line[i-1];
    w_line[0] = w0[STATE_W-1:0];
    return y[SW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Random draws
  // ---------------------------------------------------------------------

  function automatic int pick_wait();
    return quiet_phase ? 0 : $urandom_range(0, 13);
  endfunction

  // mostly full-range samples, some near zero, some at the rails
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1: return SW'($urandom_range(0, 2000) - 1000);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b0, {(SW-1){1'b1}}};
          1: return {1'b1, {(SW-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] pick_half(input span_t span);
    case (span)
      SPAN_QUARTER: return $urandom_range(0, 1 << 27) - (1 << 26);  // +-0.25
      SPAN_UNIT:    return $urandom_range(0, 1 << 29) - (1 << 28);  // +-1.0
      SPAN_FULL:    return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h1000_0000;   // +1.0
          4: return 32'hF000_0000;   // -1.0
          5: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // feedback taps and the gain/feedforward taps get separate ranges, so a
  // quarter range on a1..a4 keeps the filter stable
  task automatic plan_random_coefs(input span_t a_span, input span_t b_span);
    logic [HALF_W-1:0] half;
    for (int k = 0; k < NUM_COEF; k++) begin
      half = pick_half((k >= C_A1 && k <= C_A4) ? a_span : b_span);
      if (k % 2 == 1)
        coef_plan[k/2][HALF_W-1:0] = half;
      else
        coef_plan[k/2][CFG_DATA_W-1:HALF_W] = half;
    end
  endtask

  task automatic plan_flat_coefs(input logic [HALF_W-1:0] half);
    for (int r = 0; r < NUM_REGS; r++)
      coef_plan[r] = {half, half};
  endtask

  // ---------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------

  // writes all five words back to back, then one write past the last
  // register, which the block must drop
  task automatic program_coefs();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_GAIN_A1 + CFG_IDX_W'(r);
      cfg_wdata <= coef_plan[r];
      coef_words[r] = coef_plan[r];
      @(posedge clk);
    end
    cfg_index <= CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle check at the falling edge, where all rising-edge updates have
  // settled; returns on the following rising edge
  task automatic drain();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0);
    @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_samples.push_back(pick_sample());
  endtask

  // ---------------------------------------------------------------------
  // Input driver: one item at a time from pending_samples, with a random
  // gap after each accepted item. in_valid gets a single NBA per edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_input
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_samples.push_back(filter_sample(in_sample_in));
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0)
          send_gap--;
        else if (pending_samples.size() > 0) begin
          in_sample_in <= pending_samples.pop_front();
          send_gap = pick_wait();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------
  // Long hold-off: twice in the run the receiver stays off until hold_left,
  // loaded from LONG_HOLD, runs out; the block backs up and stalls its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left  = 0;
      hold_count = 0;
      hold_off  <= 1'b0;
    end else begin
      if (hold_left > 0)
        hold_left--;
      if (out_valid && out_ready) begin
        hold_count++;
        if (hold_count == 250 || hold_count == 1000)
          hold_left = LONG_HOLD;
      end
      hold_off <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: checks each item against the oldest expectation, then
  // drops ready for a random number of cycles, or while hold_off is set.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    logic                 take;
    logic signed [SW-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  = 0;
    end else begin
      take = out_ready;
      if (out_valid && out_ready) begin
        take = 1'b0;
        recv_gap = pick_wait();
        results_seen++;
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d arrived with nothing expected: got %0d",
                     results_seen, out_sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: expected %0d got %0d",
                       results_seen, want, out_sample_out);
          end
        end
      end
      if (hold_off)
        take = 1'b0;
      else if (!take) begin
        if (recv_gap > 0)
          recv_gap--;
        else
          take = 1'b1;
      end
      out_ready <= take;
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    span_t a_span;
    span_t b_span;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    quiet_phase  = 1'b0;
    errors       = 0;
    results_seen = 0;
    cycle_count  = 0;
    for (int r = 0; r < NUM_REGS; r++) coef_words[r] = '0;
    for (int i = 0; i < ORDER; i++) w_line[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients still at reset (all zero): every output must be zero,
    // whatever the input, rails included.
    pending_samples.push_back('0);
    pending_samples.push_back({1'b0, {(SW-1){1'b1}}});
    pending_samples.push_back({1'b1, {(SW-1){1'b0}}});
    pending_samples.push_back(24'sd1);
    pending_samples.push_back(-24'sd1);
    pending_samples.push_back(24'sh555555);
    drain();

    // Known stable lowpass: gain 1.0, a1 -0.5, a2 ~0.1, b0..b4 0.25.
    // Impulses at both rails, then ringing with quarter-weight taps, which
    // lands on exact half-LSB ties at the output rounding.
    coef_plan[REG_GAIN_A1] = {32'h1000_0000, 32'hF800_0000};
    coef_plan[REG_A2_A3]   = {32'h0199_999A, 32'h0000_0000};
    coef_plan[REG_A4_B0]   = {32'h0000_0000, 32'h0400_0000};
    coef_plan[REG_B1_B2]   = {32'h0400_0000, 32'h0400_0000};
    coef_plan[REG_B3_B4]   = {32'h0400_0000, 32'h0400_0000};
    program_coefs();
    pending_samples.push_back({1'b0, {(SW-1){1'b1}}});
    repeat (4) pending_samples.push_back('0);
    pending_samples.push_back({1'b1, {(SW-1){1'b0}}});
    repeat (2) pending_samples.push_back('0);
    pending_samples.push_back(24'sd1);
    pending_samples.push_back(-24'sd1);
    pending_samples.push_back(24'shAAAAAA);
    pending_samples.push_back('0);
    drain();

    // Every coefficient at the positive extreme, then at the negative one:
    // d, w0 and y all run into saturation.
    plan_flat_coefs(32'h7FFF_FFFF);
    program_coefs();
    queue_random(60);
    drain();
    plan_flat_coefs(32'h8000_0000);
    program_coefs();
    queue_random(60);
    drain();

    // Random coefficient sets, each followed by a block of random samples.
    // Every third phase runs with no idling at all.
    for (int p = 0; p < 8; p++) begin
      quiet_phase = (p % 3 == 1);
      case (p % 4)
        0: begin a_span = SPAN_QUARTER; b_span = SPAN_UNIT;   end
        1: begin a_span = SPAN_FULL;    b_span = SPAN_FULL;   end
        2: begin a_span = SPAN_CORNER;  b_span = SPAN_CORNER; end
        default: begin a_span = SPAN_QUARTER; b_span = SPAN_FULL; end
      endcase
      plan_random_coefs(a_span, b_span);
      program_coefs();
      queue_random(200);
      drain();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== iir_fourth_order_direct_form_two_unit.f =====
hw/rtl/iir4_pkg.sv
hw/rtl/iir4_ctrl.sv
hw/rtl/iir4_dp.sv
hw/rtl/iir_fourth_order_direct_form_two_unit.sv
hw/rtl/iir4_chk.sv
bench/tb_iir_fourth_order_direct_form_two_unit.sv
